/* rtl/btha_pkg.sv */
// Shared types and constants of the block-table heap allocator.
// Depends on nothing; imported by the allocator top level and its checker.
`default_nettype none

package btha_pkg;

	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 25;
	localparam int BASE_W  = 20;
	localparam int ENTRY_W = 3;

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [1:0]         status_t;

	// Bit positions inside one table entry.
	localparam int FLAG_TAKEN = 0;
	localparam int FLAG_FIRST = 1;
	localparam int FLAG_NEXT  = 2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam status_t ST_ALLOCATED    = 2'd0;
	localparam status_t ST_ALLOC_FAILED = 2'd1;
	localparam status_t ST_FREED        = 2'd2;
	localparam status_t ST_FREE_IGNORED = 2'd3;

	// Register index of pool_base_block.
	localparam logic REG_POOL_BASE = 1'b0;

endpackage

`default_nettype wire

/* rtl/block_table_heap_allocator_unit.sv */
// Top level of the block-table first-fit heap allocator.
// Depends on btha_pkg and btha_ram.
//
//  channel  | direction | payload                                  | handshake
//  ---------+-----------+------------------------------------------+-------------------
//  s_*      | in        | tuser: func; tdata: size_bytes, address  | tvalid/tready
//  m_*      | out       | tuser: status;  tdata: alloc_address     | tvalid/tready
//  APB      | in/out    | pool_base_block at byte address 0        | psel/penable
//
// One request is worked at a time. An allocation scans the table one entry per cycle
// through the memory read port, then writes one entry per block of the run it takes.
// A free does the range check, the block index by reciprocal multiplication and the
// alignment check in turn, then walks the entries of the chain it reads.
// After reset a clearing pass writes every entry to zero with s_tready low.
// A finished result waits in the output register while the next request is taken.
`default_nettype none

module block_table_heap_allocator_unit
	import btha_pkg::*;
#(
	parameter int NUM_BLOCKS  = 4096,
	parameter int BLOCK_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // [24:0] size_bytes, [56:25] address, [63:57] zero
	input  wire logic [0:0]  s_tuser,  // [0] func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,  // [31:0] alloc_address
	output logic      [1:0]  m_tuser,  // [1:0] status
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int IW     = $clog2(NUM_BLOCKS);
	localparam int RW     = SIZE_W + 1;
	localparam int LOG_BB = $clog2(BLOCK_BYTES);
	localparam int POOL_W = $clog2(longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES));
	localparam int SHIFT  = POOL_W + LOG_BB;
	localparam int MAG_W  = POOL_W + 1;
	localparam int PROD_W = POOL_W + MAG_W;
	localparam logic [IW-1:0]     LAST_IDX   = IW'(NUM_BLOCKS - 1);
	localparam logic [32:0]       POOL_BYTES = 33'(longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES));
	localparam logic [ADDR_W-1:0] BB32       = ADDR_W'(BLOCK_BYTES);
	localparam logic [RW-1:0]     BB_RUN     = RW'(BLOCK_BYTES);
	// Rounded-up reciprocal of the block size; exact for every offset inside the pool.
	localparam logic [MAG_W-1:0]  MAGIC      =
		MAG_W'((longint'(1) << SHIFT) / longint'(BLOCK_BYTES) + longint'(1));

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_MARK   = 4'd3;
	localparam logic [3:0] S_FRANGE = 4'd4;
	localparam logic [3:0] S_DIV    = 4'd5;
	localparam logic [3:0] S_FALIGN = 4'd6;
	localparam logic [3:0] S_FDAT   = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	// Control state.
	logic [3:0]        state_q;
	logic [IW-1:0]     clr_idx_q;
	logic              valid_s1;
	logic              issued_all_q;
	logic              m_tvalid_q;
	logic [BASE_W-1:0] base_q;
	logic [ADDR_W-1:0] pool_start_q;

	// Payload and working registers.
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] off_q;
	logic [IW-1:0]     quo_q;
	logic [IW-1:0]     rd_idx_q;
	logic [IW-1:0]     idx_s1;
	logic [RW-1:0]     run_q;
	logic [IW-1:0]     start_q;
	logic [IW-1:0]     wr_idx_q;
	logic [IW-1:0]     last_q;
	logic [IW-1:0]     pos_q;
	logic              head_q;
	logic [ADDR_W-1:0] prod_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [31:0]       m_tdata_q;
	status_t           m_tuser_q;

	// Memory port.
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [IW-1:0] ram_raddr;
	entry_t        ram_rdata;

	logic              in_req;
	logic              cfg_wr;
	logic              scan_issue;
	logic [RW-1:0]     run_next;
	logic              run_fits;
	logic [IW-1:0]     run_first;
	entry_t            mark_entry;
	logic              free_reject;
	logic              chain_more;
	logic [PROD_W-1:0] div_prod;
	logic              div_exact;
	logic [SIZE_W-1:0] in_size;
	logic [ADDR_W-1:0] in_addr;

	assign in_size = s_tdata[SIZE_W-1:0];
	assign in_addr = s_tdata[SIZE_W +: ADDR_W];

	assign s_tready = (state_q == S_IDLE);
	assign in_req   = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_BASE);
	assign prdata   = (paddr[2] == REG_POOL_BASE) ? {{(32 - BASE_W){1'b0}}, base_q} : '0;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign scan_issue = (state_q == S_SCAN) && !issued_all_q;
	assign run_next   = run_q + BB_RUN;
	assign run_fits   = run_next >= RW'(size_q);
	assign run_first  = (run_q == '0) ? idx_s1 : start_q;

	always_comb begin
		mark_entry = '0;
		mark_entry[FLAG_TAKEN] = 1'b1;
		mark_entry[FLAG_FIRST] = (wr_idx_q == start_q);
		mark_entry[FLAG_NEXT]  = (wr_idx_q != last_q);
	end

	// The first entry of a free must carry the first-of-allocation flag.
	assign free_reject = head_q && !ram_rdata[FLAG_FIRST];
	assign chain_more  = ram_rdata[FLAG_NEXT] && (pos_q != LAST_IDX);

	// The offset is below the pool size here, so the high product bits give the block index.
	assign div_prod  = PROD_W'(off_q[POOL_W-1:0]) * PROD_W'(MAGIC);
	assign div_exact = ((ADDR_W'(quo_q) * BB32) == off_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_idx_q;
		ram_wdata = '0;
		ram_raddr = rd_idx_q;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_MARK: begin
				ram_we    = 1'b1;
				ram_waddr = wr_idx_q;
				ram_wdata = mark_entry;
			end
			S_FALIGN: begin
				ram_raddr = quo_q;
			end
			S_FDAT: begin
				ram_we    = !free_reject;
				ram_waddr = pos_q;
				ram_raddr = pos_q + IW'(1);
			end
			default: begin
			end
		endcase
	end

	btha_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_idx_q    <= '0;
			valid_s1     <= 1'b0;
			issued_all_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
			base_q       <= '0;
			pool_start_q <= '0;
		end else begin
			if (cfg_wr) begin
				base_q       <= pwdata[BASE_W-1:0];
				pool_start_q <= ADDR_W'(pwdata[BASE_W-1:0]) * BB32;
			end
			if ((state_q == S_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			valid_s1 <= scan_issue;
			if (scan_issue && (rd_idx_q == LAST_IDX)) begin
				issued_all_q <= 1'b1;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IW'(1);
					if (clr_idx_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					issued_all_q <= 1'b0;
					if (in_req) begin
						if (s_tuser[0] == FUNC_ALLOC) begin
							if ((in_size == '0) || ({8'b0, in_size} > POOL_BYTES)) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							state_q <= S_FRANGE;
						end
					end
				end
				S_SCAN: begin
					if (valid_s1 && !ram_rdata[FLAG_TAKEN] && run_fits) begin
						state_q <= S_MARK;
					end else if (valid_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= S_DONE;
					end
				end
				S_MARK: begin
					if (wr_idx_q == last_q) begin
						state_q <= S_DONE;
					end
				end
				S_FRANGE: begin
					state_q <= ({1'b0, off_q} < POOL_BYTES) ? S_DIV : S_DONE;
				end
				S_DIV: begin
					state_q <= S_FALIGN;
				end
				S_FALIGN: begin
					state_q <= div_exact ? S_FDAT : S_DONE;
				end
				S_FDAT: begin
					if (free_reject || !chain_more) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (scan_issue) begin
			rd_idx_q <= rd_idx_q + IW'(1);
		end
		case (state_q)
			S_IDLE: begin
				size_q       <= in_size;
				off_q        <= in_addr - pool_start_q;
				rd_idx_q     <= '0;
				run_q        <= '0;
				res_status_q <= (s_tuser[0] == FUNC_ALLOC) ? ST_ALLOC_FAILED : ST_FREE_IGNORED;
				res_addr_q   <= '0;
			end
			S_SCAN: begin
				if (valid_s1) begin
					if (ram_rdata[FLAG_TAKEN]) begin
						run_q <= '0;
					end else begin
						run_q   <= run_next;
						start_q <= run_first;
						if (run_fits) begin
							wr_idx_q <= run_first;
							last_q   <= idx_s1;
							prod_q   <= ADDR_W'(run_first) * BB32;
						end
					end
				end
			end
			S_MARK: begin
				wr_idx_q <= wr_idx_q + IW'(1);
				if (wr_idx_q == last_q) begin
					res_status_q <= ST_ALLOCATED;
					res_addr_q   <= pool_start_q + prod_q;
				end
			end
			S_DIV: begin
				quo_q <= div_prod[SHIFT +: IW];
			end
			S_FALIGN: begin
				pos_q  <= quo_q;
				head_q <= 1'b1;
			end
			S_FDAT: begin
				head_q <= 1'b0;
				pos_q  <= pos_q + IW'(1);
				if (!free_reject && !chain_more) begin
					res_status_q <= ST_FREED;
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= res_addr_q;
					m_tuser_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/btha_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the block table.
`default_nettype none

module btha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/btha_checker.sv */
// Port-level checker for the block-table heap allocator, bound to its top level.
// Depends on btha_pkg for the status codes.
`default_nettype none

module btha_checker
	import btha_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only a successful allocation carries an address.
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_ALLOCATED) |-> m_tdata == '0)
		else $error("nonzero address on a result that is not an allocation");

	// The block works one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in progress");

	// Nothing is offered or taken while reset is held.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid && !s_tready)
		else $error("handshake active during reset");

endmodule

bind block_table_heap_allocator_unit btha_checker u_btha_checker (.*);

`default_nettype wire
